// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the queue controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge while out of reset.
`define SMPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds while out of reset.
`define SMPQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SMPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMPQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- hw/rtl/smpq_pkg.sv -----
`timescale 1ns / 1ps

package smpq_pkg;

  // Operation codes; the unused code behaves as a query
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  // Status flags of one result beat
  typedef struct packed {
    logic is_empty;
    logic is_full;
    logic overflow;
  } res_flags_t;

endpackage

// ----- hw/rtl/smpq_ram.sv -----
`timescale 1ns / 1ps

module smpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/smpq_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smpq_ctrl #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 operation_i,
  input  logic [VALUE_WIDTH-1:0]     value_i,
  input  logic                       res_free_i,
  output logic                       res_load_o,
  output logic [VALUE_WIDTH-1:0]     res_top_o,
  output smpq_pkg::res_flags_t       res_flags_o,
  output logic                       ram_we_o,
  output logic [$clog2(DEPTH)-1:0]   ram_waddr_o,
  output logic [VALUE_WIDTH-1:0]     ram_wdata_o,
  output logic                       ram_re_o,
  output logic [$clog2(DEPTH)-1:0]   ram_raddr_o,
  input  logic [VALUE_WIDTH-1:0]     ram_rdata_i
);

  import smpq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_PUSH_RD  = 5'b00010,
    ST_PUSH_CMP = 5'b00100,
    ST_TOP_RD   = 5'b01000,
    ST_RESULT   = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [CW-1:0]          count_q, count_d;
  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic                   refused_q, refused_d;
  logic [CW-1:0]          count_dec;
  logic                   stored_less;

  // Shared compare unit: is the stored entry smaller than the new value
  assign stored_less = $signed(ram_rdata_i) < $signed(value_q);
  assign count_dec   = count_q - CW'(1);

  // Sequencer: insertion walk, top read, result hand-off
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    count_d     = count_q;
    value_d     = value_q;
    refused_d   = refused_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_q;
    ram_wdata_o = value_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = pos_q - AW'(1);
    res_load_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          value_d   = value_i;
          refused_d = 1'b0;
          state_d   = ST_TOP_RD;
          case (operation_i)
            OP_PUSH: begin
              if (count_q == COUNT_MAX) begin
                refused_d = 1'b1;
              end else begin
                pos_d   = count_q[AW-1:0];
                state_d = ST_PUSH_RD;
              end
            end
            OP_POP: begin
              if (count_q != '0) begin
                count_d = count_dec;
              end
            end
            default: begin
              count_d = count_q;
            end
          endcase
        end
      end
      ST_PUSH_RD: begin
        if (pos_q == '0) begin
          // Reached the bottom slot: drop the value in
          ram_we_o = 1'b1;
          count_d  = count_q + CW'(1);
          state_d  = ST_TOP_RD;
        end else begin
          ram_re_o = 1'b1;
          state_d  = ST_PUSH_CMP;
        end
      end
      ST_PUSH_CMP: begin
        ram_we_o = 1'b1;
        if (stored_less) begin
          // Move the smaller entry up one slot and keep walking
          ram_wdata_o = ram_rdata_i;
          pos_d       = pos_q - AW'(1);
          state_d     = ST_PUSH_RD;
        end else begin
          count_d = count_q + CW'(1);
          state_d = ST_TOP_RD;
        end
      end
      ST_TOP_RD: begin
        ram_re_o    = count_q != '0;
        ram_raddr_o = count_dec[AW-1:0];
        state_d     = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_free_i) begin
          res_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      refused_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      refused_q <= refused_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    value_q <= value_d;
  end

  assign in_ready_o           = state_q == ST_IDLE;
  assign res_top_o            = (count_q == '0) ? '1 : ram_rdata_i;
  assign res_flags_o.is_empty = count_q == '0;
  assign res_flags_o.is_full  = count_q == COUNT_MAX;
  assign res_flags_o.overflow = refused_q;

  `SMPQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= COUNT_MAX, "entry count above depth")
  `SMPQ_ASSERT(a_cmp_after_rd, clk_i, rst_ni, (state_q == ST_PUSH_CMP) |-> $past(state_q == ST_PUSH_RD), "compare without read")
  `SMPQ_ASSERT_NEVER(a_push_room, clk_i, rst_ni, ((state_q == ST_PUSH_RD) || (state_q == ST_PUSH_CMP)) && (count_q == COUNT_MAX), "insert walk on full store")
  `SMPQ_ASSERT(a_count_step, clk_i, rst_ni, (count_q == $past(count_q)) || (count_q == ($past(count_q) + CW'(1))) || ((count_q + CW'(1)) == $past(count_q)), "count moved by more than one")

endmodule

// ----- hw/rtl/sorted_min_priority_queue.sv -----
`timescale 1ns / 1ps
// Channel | Handshake               | Payload
// in      | in_valid_i / in_ready_o | operation_i, value_i
// out     | out_valid_o / out_ready_i | top_value_o, is_empty_o, is_full_o, overflow_o
//
// Pop and query read the top entry and then hand off the result; a push walks
// down from the top entry, moving each smaller entry up one slot, with one read
// and one compare per step through the single RAM read port and the shared
// compare unit, then reads the top. in_ready_o is high only while the sequencer
// is idle. Reset clears the entry count; RAM contents need no clearing. A result
// waiting in the output register holds the sequencer in its last step only,
// after the next item has been accepted.

module sorted_min_priority_queue #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] top_value_o,
  output logic                          is_empty_o,
  output logic                          is_full_o,
  output logic                          overflow_o
);

  import smpq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                   res_free;
  logic                   res_load;
  logic [VALUE_WIDTH-1:0] res_top;
  res_flags_t             res_flags;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] top_q;
  res_flags_t             flags_q;

  smpq_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .res_free_i  (res_free),
    .res_load_o  (res_load),
    .res_top_o   (res_top),
    .res_flags_o (res_flags),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  smpq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: free when empty or draining this cycle
  assign res_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the result beat
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      top_q   <= res_top;
      flags_q <= res_flags;
    end
  end

  assign out_valid_o = out_valid_q;
  assign top_value_o = top_q;
  assign is_empty_o  = flags_q.is_empty;
  assign is_full_o   = flags_q.is_full;
  assign overflow_o  = flags_q.overflow;

endmodule
